// ===== rtl/core/npcm_pkg.sv =====
package npcm_pkg;

  // Field widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned ENTRY_W = 3 * CHAN_W;

  // Palette size: default and the width that holds the largest allowed count
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned ENTRY_CNT_W     = 13;
  // Slots that a load can reach
  localparam int unsigned LOADABLE_SLOTS  = 1 << SLOT_W;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_MATCH = 1'b1
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic load_we;     // write the request colour into the palette
    logic scan_start;  // latch the request colour, clear the scan counter
    logic scan_issue;  // read one slot and advance the counter
    logic out_load;    // move the best result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;   // counter sits at the last slot
    logic scan_done;   // last compare has landed in the best registers
    logic out_free;    // output register can take a result this cycle
  } stat_t;

endpackage

// ===== rtl/core/npcm_req_if.sv =====
interface npcm_req_if;
  logic                           valid;
  logic                           ready;
  npcm_pkg::op_e                  operation;
  logic [npcm_pkg::SLOT_W-1:0]    slot_index;
  logic [npcm_pkg::CHAN_W-1:0]    chan0;
  logic [npcm_pkg::CHAN_W-1:0]    chan1;
  logic [npcm_pkg::CHAN_W-1:0]    chan2;

  modport source (output valid, operation, slot_index, chan0, chan1, chan2, input ready);
  modport sink   (input valid, operation, slot_index, chan0, chan1, chan2, output ready);
endinterface

// ===== rtl/core/npcm_rsp_if.sv =====
interface npcm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [npcm_pkg::INDEX_W-1:0]   best_index;
  logic [npcm_pkg::DIST_W-1:0]    best_distance;

  modport source (output valid, best_index, best_distance, input ready);
  modport sink   (input valid, best_index, best_distance, output ready);
endinterface

// ===== rtl/core/npcm_ctrl.sv =====
module npcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  npcm_pkg::op_e     req_op_i,
  output logic              req_ready_o,
  input  npcm_pkg::stat_t   stat_i,
  output npcm_pkg::cmd_t    cmd_o
);
  import npcm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_op_i == OP_MATCH) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // wait for the read and distance stages to drain
        if (stat_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/npcm_dpath.sv =====
module npcm_dpath #(
  parameter int unsigned PaletteEntries = npcm_pkg::PALETTE_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [npcm_pkg::SLOT_W-1:0]   slot_index_i,
  input  logic [npcm_pkg::CHAN_W-1:0]   chan0_i,
  input  logic [npcm_pkg::CHAN_W-1:0]   chan1_i,
  input  logic [npcm_pkg::CHAN_W-1:0]   chan2_i,
  input  npcm_pkg::cmd_t                cmd_i,
  output npcm_pkg::stat_t               stat_o,
  npcm_rsp_if.source                    rsp_o
);
  import npcm_pkg::*;

  // Only the loadable part of the palette is stored; higher slots stay zero
  localparam int unsigned StoreDepth =
    (PaletteEntries < LOADABLE_SLOTS) ? PaletteEntries : LOADABLE_SLOTS;
  localparam int unsigned SaW  = $clog2(StoreDepth);
  localparam int unsigned IdxW = $clog2(PaletteEntries);

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
  endfunction

  // Palette memory and per-slot written flags
  logic [ENTRY_W-1:0] mem [StoreDepth];
  logic [StoreDepth-1:0] written_q;

  logic              slot_ok;
  logic [SaW-1:0]    wr_addr;

  assign slot_ok = ({{(ENTRY_CNT_W-SLOT_W){1'b0}}, slot_index_i}
                    < ENTRY_CNT_W'(PaletteEntries));
  assign wr_addr = slot_index_i[SaW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && slot_ok) begin
      mem[wr_addr] <= {chan2_i, chan1_i, chan0_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (cmd_i.load_we && slot_ok) begin
      written_q[wr_addr] <= 1'b1;
    end
  end

  // Match colour, held for the whole scan
  logic [CHAN_W-1:0] c0_q, c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      c0_q <= chan0_i;
      c1_q <= chan1_i;
      c2_q <= chan2_i;
    end
  end

  // Scan counter
  logic [IdxW-1:0] k_q;
  logic            in_range;
  logic [SaW-1:0]  rd_addr;

  assign stat_o.scan_last = (k_q == IdxW'(PaletteEntries - 1));
  assign in_range = ({1'b0, k_q} < (IdxW+1)'(StoreDepth));
  assign rd_addr  = k_q[SaW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.scan_start) begin
      k_q <= '0;
    end else if (cmd_i.scan_issue) begin
      k_q <= k_q + 1'b1;
    end
  end

  // Stage 1: registered palette read
  logic [ENTRY_W-1:0] rd_q;
  logic               hit1_q;
  logic               v1_q, first1_q, last1_q;
  logic [IdxW-1:0]    idx1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      hit1_q   <= in_range && written_q[rd_addr];
      first1_q <= (k_q == '0);
      last1_q  <= stat_o.scan_last;
      idx1_q   <= k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_issue;
    end
  end

  // Stage 2: squared distance
  logic [ENTRY_W-1:0] entry;
  logic [DIST_W-1:0]  dist_d, dist_q;
  logic               v2_q, first2_q, last2_q;
  logic [IdxW-1:0]    idx2_q;

  assign entry  = hit1_q ? rd_q : '0;
  assign dist_d = DIST_W'(sq_diff(c0_q, entry[CHAN_W-1:0]))
                + DIST_W'(sq_diff(c1_q, entry[2*CHAN_W-1:CHAN_W]))
                + DIST_W'(sq_diff(c2_q, entry[3*CHAN_W-1:2*CHAN_W]));

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      dist_q   <= dist_d;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      idx2_q   <= idx1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  // Stage 3: keep the first minimum
  logic [DIST_W-1:0] best_dist_q;
  logic [IdxW-1:0]   best_idx_q;
  logic              done_q;

  always_ff @(posedge clk_i) begin
    if (v2_q && (first2_q || (dist_q < best_dist_q))) begin
      best_dist_q <= dist_q;
      best_idx_q  <= idx2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q && last2_q;
    end
  end

  assign stat_o.scan_done = done_q;

  // Output register
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [DIST_W-1:0]  out_dist_q;

  assign stat_o.out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= INDEX_W'(best_idx_q);
      out_dist_q <= best_dist_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.best_index    = out_idx_q;
  assign rsp_o.best_distance = out_dist_q;

endmodule

// ===== rtl/core/nearest_palette_color_match.sv =====
// Channel  Dir  Payload
// req_i    in   operation, slot_index, chan0, chan1, chan2
// rsp_o    out  best_index, best_distance (one per match request)
//
// A load request is written into the palette as it is taken. A match request
// shows its result once the scan is through: the scan compares one palette
// slot per cycle through a single memory read port, three pipeline stages
// drain, then the output register loads. Requests are taken only while no
// scan runs; after a match, only once the output register has its result.
// A finished result waits there while loads are still taken; a stalled output
// holds the next match result back, and no request is taken meanwhile.
// Reset clears the palette at once through per-slot written flags.
module nearest_palette_color_match #(
  parameter int unsigned PaletteEntries = npcm_pkg::PALETTE_ENTRIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  npcm_req_if.sink     req_i,
  npcm_rsp_if.source   rsp_o
);
  import npcm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  npcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  npcm_dpath #(
    .PaletteEntries (PaletteEntries)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_index_i (req_i.slot_index),
    .chan0_i      (req_i.chan0),
    .chan1_i      (req_i.chan1),
    .chan2_i      (req_i.chan2),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_o        (rsp_o)
  );

endmodule
